### rtl/orr_pkg.sv
// shared types and constants of the overwrite-oldest record ring
// no dependencies
package orr_pkg;

  // field widths of the request, the response and the capacity register
  localparam int unsigned PAYLOAD_W = 17;
  localparam int unsigned CAP_W     = 17;
  localparam int unsigned EVICT_W   = 13;
  localparam int unsigned OFFSET_W  = 16;
  localparam int unsigned USED_W    = 17;
  // record size is header plus payload, one bit wider than the payload
  localparam int unsigned SIZE_W    = PAYLOAD_W + 1;

  // capacity limits
  localparam int unsigned CAP_MIN       = 16;
  localparam int unsigned CAP_RESET_VAL = 65536;
  localparam int unsigned CAP_FIELD_MAX = (1 << CAP_W) - 1;

  // default build sizes
  localparam int unsigned DEF_RING_BYTES   = 65536;
  localparam int unsigned DEF_HEADER_BYTES = 16;
  localparam int unsigned DEF_MAX_RECORDS  = 4096;

  // response status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TOO_BIG = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // latch a new request
    logic pop;     // evict the oldest record
    logic commit;  // place the record and write the response
  } orr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic too_big;   // record larger than the ring
    logic need_pop;  // oldest record has to go before the new one fits
    logic out_free;  // response register can take a new response
  } orr_sts_t;

endpackage

### rtl/orr_req_if.sv
// request channel: payload length of one new record
// depends on orr_pkg
interface orr_req_if;
  import orr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PAYLOAD_W-1:0] payload_bytes;

  modport source (output valid, output payload_bytes, input ready);
  modport sink (input valid, input payload_bytes, output ready);
endinterface

### rtl/orr_rsp_if.sv
// response channel: status, eviction count, offset and fill of one request
// depends on orr_pkg
interface orr_rsp_if;
  import orr_pkg::*;

  logic                valid;
  logic                ready;
  logic                status;
  logic [EVICT_W-1:0]  evicted_count;
  logic [OFFSET_W-1:0] record_offset;
  logic [USED_W-1:0]   used_after;

  modport source (
    output valid, output status, output evicted_count, output record_offset,
    output used_after, input ready
  );
  modport sink (
    input valid, input status, input evicted_count, input record_offset,
    input used_after, output ready
  );
endinterface

### rtl/orr_ctrl.sv
// controller of the record ring: takes a request, steps the evictions,
// then commits the record; depends on orr_pkg
module orr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  orr_pkg::orr_sts_t sts_i,
  output orr_pkg::orr_cmd_t cmd_o
);
  import orr_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_EVICT = 1'b1;

  logic state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVICT;
        end
      end
      S_EVICT: begin
        if (!sts_i.too_big && sts_i.need_pop) begin
          cmd_o.pop = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/orr_dp.sv
// datapath of the record ring: ring pointers, record size memory,
// eviction arithmetic and the response register; depends on orr_pkg
module orr_dp #(
  parameter int unsigned RING_BYTES   = orr_pkg::DEF_RING_BYTES,
  parameter int unsigned HEADER_BYTES = orr_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_RECORDS  = orr_pkg::DEF_MAX_RECORDS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [orr_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  logic [orr_pkg::PAYLOAD_W-1:0] payload_bytes_i,
  input  orr_pkg::orr_cmd_t            cmd_i,
  output orr_pkg::orr_sts_t            sts_o,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output logic                         rsp_status_o,
  output logic [orr_pkg::EVICT_W-1:0]  rsp_evicted_count_o,
  output logic [orr_pkg::OFFSET_W-1:0] rsp_record_offset_o,
  output logic [orr_pkg::USED_W-1:0]   rsp_used_after_o
);
  import orr_pkg::*;

  localparam int unsigned SLOT_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_RECORDS + 1);
  localparam int unsigned CAP_MAX = (RING_BYTES > CAP_FIELD_MAX) ? CAP_FIELD_MAX
                                                                 : RING_BYTES;
  localparam int unsigned CAP_RST = (CAP_RESET_VAL > CAP_MAX) ? CAP_MAX
                                                              : CAP_RESET_VAL;
  localparam logic [CAP_W-1:0]  CapMax    = CAP_W'(CAP_MAX);
  localparam logic [CAP_W-1:0]  CapMin    = CAP_W'(CAP_MIN);
  localparam logic [CAP_W-1:0]  CapRst    = CAP_W'(CAP_RST);
  localparam logic [SIZE_W-1:0] HeaderSz  = SIZE_W'(HEADER_BYTES);
  localparam logic [SLOT_W-1:0] LastSlot  = SLOT_W'(MAX_RECORDS - 1);
  localparam logic [CNT_W-1:0]  CntFull   = CNT_W'(MAX_RECORDS);

  // ring state
  logic [CAP_W-1:0]  cap_q;
  logic [CAP_W-1:0]  head_q, head_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [SLOT_W-1:0] oldest_q, oldest_d;
  logic [SLOT_W-1:0] newest_q, newest_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SIZE_W-1:0] size_q;
  logic [EVICT_W-1:0] evicted_q;

  // record size memory
  logic [CAP_W-1:0] size_mem [MAX_RECORDS];
  logic [CAP_W-1:0] rd_size_q;

  // response register
  logic                rsp_valid_q;
  logic                rsp_status_q;
  logic [EVICT_W-1:0]  rsp_evicted_q;
  logic [OFFSET_W-1:0] rsp_offset_q;
  logic [USED_W-1:0]   rsp_used_q;

  // arithmetic
  logic [CAP_W-1:0]  free_bytes;
  logic [CAP_W:0]    head_sum;
  logic [USED_W-1:0] used_eff;
  logic [CAP_W:0]    off_sum;
  logic [CAP_W-1:0]  new_offset;
  logic [USED_W-1:0] new_used;
  logic [CAP_W-1:0]  cfg_cap;

  // status toward the controller
  assign free_bytes     = cap_q - used_q;
  assign sts_o.too_big  = size_q > {1'b0, cap_q};
  assign sts_o.need_pop = (count_q != '0) &&
                          (({1'b0, free_bytes} < size_q) || (count_q >= CntFull));
  assign sts_o.out_free = !rsp_valid_q || rsp_ready_i;

  // placement of the new record at the tail
  assign used_eff   = (count_q == '0) ? '0 : used_q;
  assign off_sum    = {1'b0, head_q} + {1'b0, used_eff};
  assign new_offset = (off_sum >= {1'b0, cap_q}) ? CAP_W'(off_sum - {1'b0, cap_q})
                                                 : off_sum[CAP_W-1:0];
  assign new_used   = used_eff + USED_W'(size_q);

  // head advance past the evicted record
  assign head_sum = {1'b0, head_q} + {1'b0, rd_size_q};

  // clamped capacity write
  always_comb begin
    cfg_cap = cfg_wdata_i;
    if (cfg_wdata_i < CapMin) begin
      cfg_cap = CapMin;
    end else if (cfg_wdata_i > CapMax) begin
      cfg_cap = CapMax;
    end
  end

  // next values of the ring pointers
  always_comb begin
    head_d   = head_q;
    used_d   = used_q;
    oldest_d = oldest_q;
    newest_d = newest_q;
    count_d  = count_q;
    if (cfg_we_i) begin
      head_d   = '0;
      used_d   = '0;
      oldest_d = '0;
      newest_d = '0;
      count_d  = '0;
    end else if (cmd_i.pop) begin
      used_d   = (rd_size_q > used_q) ? '0 : used_q - rd_size_q;
      head_d   = (head_sum >= {1'b0, cap_q}) ? CAP_W'(head_sum - {1'b0, cap_q})
                                             : head_sum[CAP_W-1:0];
      oldest_d = (oldest_q == LastSlot) ? '0 : oldest_q + 1'b1;
      count_d  = count_q - 1'b1;
    end else if (cmd_i.commit && !sts_o.too_big) begin
      used_d   = new_used;
      newest_d = (newest_q == LastSlot) ? '0 : newest_q + 1'b1;
      count_d  = count_q + 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapRst;
      head_q      <= '0;
      used_q      <= '0;
      oldest_q    <= '0;
      newest_q    <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_cap;
      end
      head_q   <= head_d;
      used_q   <= used_d;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      count_q  <= count_d;
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // request size and eviction count
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q    <= HeaderSz + SIZE_W'(payload_bytes_i);
      evicted_q <= '0;
    end else if (cmd_i.pop) begin
      evicted_q <= evicted_q + 1'b1;
    end
  end

  // size memory: write on a commit that fits, read the next oldest slot every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !sts_o.too_big) begin
      size_mem[newest_q] <= size_q[CAP_W-1:0];
    end
    rd_size_q <= size_mem[oldest_d];
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (sts_o.too_big) begin
        rsp_status_q  <= STATUS_TOO_BIG;
        rsp_evicted_q <= '0;
        rsp_offset_q  <= '0;
        rsp_used_q    <= used_q;
      end else begin
        rsp_status_q  <= STATUS_OK;
        rsp_evicted_q <= evicted_q;
        rsp_offset_q  <= new_offset[OFFSET_W-1:0];
        rsp_used_q    <= new_used;
      end
    end
  end

  assign rsp_valid_o         = rsp_valid_q;
  assign rsp_status_o        = rsp_status_q;
  assign rsp_evicted_count_o = rsp_evicted_q;
  assign rsp_record_offset_o = rsp_offset_q;
  assign rsp_used_after_o    = rsp_used_q;

endmodule

### rtl/overwrite_oldest_record_ring_unit.sv
// top level of the overwrite-oldest record ring allocator
// depends on orr_pkg, orr_req_if, orr_rsp_if, orr_ctrl and orr_dp
//
// Usage: each request on req_i carries the payload length of a new record;
// the record takes HEADER_BYTES plus that length. Each request yields one
// response on rsp_o: status ok with the number of oldest records evicted,
// the byte offset of the new record header and the bytes in use after it,
// or status too big (record larger than the ring) with nothing changed.
// Ring capacity is written through cfg_we_i / cfg_wdata_i; the user must do
// so only while the block is idle; the block does not enforce this. A write
// is clamped to 16 .. RING_BYTES (at most 131071) and empties the ring.
// Timing: one request at a time; after accept the block evicts as needed,
// then commits; evicting reads one stored record size per cycle from the
// size memory port. req_i.ready is high only while no request is in work,
// so the next request can be taken in the cycle after the commit.
// The response sits in an output register; while the receiver stalls, the
// next request is still accepted and worked up to its commit, where it
// waits for the register to free up.
// Reset empties the ring and sets the capacity to 65536 (or RING_BYTES if
// smaller); the size memory needs no clearing.
module overwrite_oldest_record_ring_unit #(
  parameter int unsigned RING_BYTES   = orr_pkg::DEF_RING_BYTES,
  parameter int unsigned HEADER_BYTES = orr_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_RECORDS  = orr_pkg::DEF_MAX_RECORDS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  orr_req_if.sink                   req_i,
  orr_rsp_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [orr_pkg::CAP_W-1:0] cfg_wdata_i
);
  import orr_pkg::*;

  orr_cmd_t cmd;
  orr_sts_t sts;

  // sequencer
  orr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // ring state and arithmetic
  orr_dp #(
    .RING_BYTES   (RING_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_RECORDS  (MAX_RECORDS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .payload_bytes_i     (req_i.payload_bytes),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .rsp_valid_o         (rsp_o.valid),
    .rsp_ready_i         (rsp_o.ready),
    .rsp_status_o        (rsp_o.status),
    .rsp_evicted_count_o (rsp_o.evicted_count),
    .rsp_record_offset_o (rsp_o.record_offset),
    .rsp_used_after_o    (rsp_o.used_after)
  );

  // at most one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.load, cmd.pop, cmd.commit}) <= 1)
    else $error("more than one command in a cycle");

  // no eviction for a request that is too big
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.too_big)
    else $error("eviction for a too big request");

  // a commit shows up as a valid response next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> rsp_o.valid)
    else $error("commit without response");

  // the block is busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !req_i.ready)
    else $error("ready right after a request");

endmodule

### tb/orr_alloc_checker.sv
`timescale 1ns / 1ps
// response checker for the record ring allocator: predicts every response
// from the accepted requests and capacity writes; depends on orr_pkg and the channel interfaces
module orr_alloc_checker
  import orr_pkg::*;
#(
  parameter int unsigned RING_BYTES   = DEF_RING_BYTES,
  parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int unsigned MAX_RECORDS  = DEF_MAX_RECORDS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  orr_req_if               req_mon,
  orr_rsp_if               rsp_mon,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  output int unsigned      error_count_o,
  output int unsigned      outstanding_o
);

  typedef struct packed {
    logic                status;
    logic [EVICT_W-1:0]  evicted_count;
    logic [OFFSET_W-1:0] record_offset;
    logic [USED_W-1:0]   used_after;
  } alloc_result_t;

  // shadow of the ring bookkeeping
  logic [CAP_W-1:0]    ring_cap;
  logic [OFFSET_W-1:0] head_off;
  logic [USED_W-1:0]   used_cnt;
  logic [SIZE_W-1:0]   stored_sizes[$];

  alloc_result_t expected_allocs[$];
  int unsigned   error_total;

  assign error_count_o = error_total;

  function automatic logic [CAP_W-1:0] clamp_capacity(int unsigned value);
    if (value < CAP_MIN) return CAP_W'(CAP_MIN);
    if (value > RING_BYTES) return CAP_W'(RING_BYTES);
    return CAP_W'(value);
  endfunction

  function automatic void empty_ring();
    head_off = '0;
    used_cnt = '0;
    stored_sizes.delete();
  endfunction

  // evict the oldest record from the head
  function automatic void drop_oldest();
    int unsigned sz;
    sz = stored_sizes.pop_front();
    used_cnt = (sz > used_cnt) ? '0 : USED_W'(used_cnt - sz);
    head_off = OFFSET_W'((head_off + sz) % ring_cap);
  endfunction

  // room for one record: evict until it fits, then place it at the tail
  function automatic alloc_result_t predict_alloc(logic [PAYLOAD_W-1:0] payload);
    alloc_result_t r;
    int unsigned   rec_size;
    int unsigned   evicted;
    int unsigned   place;
    rec_size = HEADER_BYTES + payload;
    evicted  = 0;
    if (rec_size > ring_cap) begin
      r.status        = STATUS_TOO_BIG;
      r.evicted_count = '0;
      r.record_offset = '0;
      r.used_after    = used_cnt;
      return r;
    end
    while (stored_sizes.size() > 0 && ring_cap - used_cnt < rec_size) begin
      drop_oldest();
      evicted++;
    end
    // size table full: one more record has to go
    if (stored_sizes.size() >= MAX_RECORDS) begin
      drop_oldest();
      evicted++;
    end
    if (stored_sizes.size() == 0) used_cnt = '0;
    place = head_off + used_cnt;
    if (place >= ring_cap) place -= ring_cap;
    stored_sizes.push_back(SIZE_W'(rec_size));
    used_cnt = USED_W'(used_cnt + rec_size);
    r.status        = STATUS_OK;
    r.evicted_count = EVICT_W'(evicted);
    r.record_offset = OFFSET_W'(place);
    r.used_after    = used_cnt;
    return r;
  endfunction

  function automatic void flag_error(string what);
    if (error_total < 10) $display("%0t %s", $time, what);
    error_total++;
  endfunction

  // compare one accepted response against the oldest prediction
  function automatic void check_response();
    alloc_result_t want;
    alloc_result_t got;
    got.status        = rsp_mon.status;
    got.evicted_count = rsp_mon.evicted_count;
    got.record_offset = rsp_mon.record_offset;
    got.used_after    = rsp_mon.used_after;
    if (expected_allocs.size() == 0) begin
      flag_error($sformatf("unexpected response: status %0d evicted %0d offset %0d used %0d",
                           got.status, got.evicted_count, got.record_offset, got.used_after));
      return;
    end
    want = expected_allocs.pop_front();
    if (got.status !== want.status || got.evicted_count !== want.evicted_count ||
        got.record_offset !== want.record_offset || got.used_after !== want.used_after) begin
      flag_error($sformatf({"response mismatch: expected status %0d evicted %0d offset %0d",
                            " used %0d, got status %0d evicted %0d offset %0d used %0d"},
                           want.status, want.evicted_count, want.record_offset,
                           want.used_after, got.status, got.evicted_count,
                           got.record_offset, got.used_after));
    end
  endfunction

  // track capacity writes, requests and responses
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_cap = clamp_capacity(CAP_RESET_VAL);
      empty_ring();
      expected_allocs.delete();
      error_total = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        ring_cap = clamp_capacity(cfg_wdata_i);
        empty_ring();
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_allocs.push_back(predict_alloc(req_mon.payload_bytes));
      end
      if (rsp_mon.valid && rsp_mon.ready) check_response();
      outstanding_o <= expected_allocs.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// top of the record ring allocator testbench: clock, reset, requests and capacity writes
// depends on orr_pkg, the channel interfaces, the allocator and orr_alloc_checker
module testbench;
  import orr_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PHASE_ITEMS  = 100;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;
  logic             steady;
  int unsigned      error_count;
  int unsigned      outstanding;
  int unsigned      cycle_count = 0;

  orr_req_if req_if();
  orr_rsp_if rsp_if();

  overwrite_oldest_record_ring_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  orr_alloc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_if),
    .rsp_mon       (rsp_if),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver stalls about one cycle in five outside the steady stretch
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // payloads skewed to small records, with fit boundaries and full-range values
  function automatic logic [PAYLOAD_W-1:0] pick_payload(int unsigned cap);
    int unsigned room;
    int unsigned roll;
    room = cap - DEF_HEADER_BYTES;
    roll = $urandom_range(99);
    if (roll < 40) return PAYLOAD_W'($urandom_range(31, 0));
    if (roll < 65) return PAYLOAD_W'($urandom_range(room / 8, 0));
    if (roll < 80) return PAYLOAD_W'($urandom_range(room, 0));
    if (roll < 90) return PAYLOAD_W'(room + $urandom_range(2, 0) - 1);
    return PAYLOAD_W'($urandom);
  endfunction

  // one request, with an occasional gap before it
  task automatic send_req(input logic [PAYLOAD_W-1:0] payload);
    if (!steady && $urandom_range(99) < 20) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.payload_bytes <= payload;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // drain all responses, then let the block settle
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // corner payloads at the reset capacity of 65536 bytes
  logic [PAYLOAD_W-1:0] corner_payloads[16] = '{
    17'd0, 17'd1, 17'd15, 17'd16, 17'd65519, 17'd65520, 17'd0, 17'd65521,
    17'd65536, 17'd131071, 17'd43690, 17'd87381, 17'd4080, 17'd0, 17'd32768,
    17'd32752
  };

  // capacities per phase: clamped low, clamped high, mid values, random last
  int unsigned phase_caps[10] = '{16, 15, 0, 131071, 65537, 2000, 300, 100, 4096, 0};

  initial begin
    int unsigned cap;
    int unsigned cap_eff;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.payload_bytes = '0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    steady               = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full-size fit, too big, bit patterns, whole-ring eviction
    foreach (corner_payloads[i]) send_req(corner_payloads[i]);
    wait_idle();

    // random phases, one capacity each
    for (int p = 0; p < $size(phase_caps); p++) begin
      cap = (p == $size(phase_caps) - 1) ? $urandom_range(65536, 16) : phase_caps[p];
      cap_eff = (cap < CAP_MIN) ? CAP_MIN : (cap > DEF_RING_BYTES) ? DEF_RING_BYTES : cap;
      steady = (p == 4);
      write_capacity(CAP_W'(cap));
      repeat (PHASE_ITEMS) send_req(pick_payload(cap_eff));
      wait_idle();
    end
    steady = 1'b0;

    if (error_count == 0 && outstanding == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/orr_pkg.sv
rtl/orr_req_if.sv
rtl/orr_rsp_if.sv
rtl/orr_ctrl.sv
rtl/orr_dp.sv
rtl/overwrite_oldest_record_ring_unit.sv
tb/orr_alloc_checker.sv
tb/testbench.sv
